>>> hdl/fqwc_pkg.sv
`default_nettype none

package fqwc_pkg;

    localparam int AREA_WORDS = 36864;
    localparam int QUAD_COUNT = (AREA_WORDS + 3) / 4;
    localparam int QUAD_AW    = $clog2(QUAD_COUNT);
    localparam int NUM_W      = 16;
    localparam int WORD_W     = 32;
    localparam int QUAD_WORDS = 4;
    localparam int QUAD_W     = WORD_W * QUAD_WORDS;

    localparam logic [NUM_W:0]      AREA_LIMIT  = (NUM_W + 1)'(AREA_WORDS);
    localparam logic [QUAD_AW-1:0]  LAST_QUAD   = QUAD_AW'(QUAD_COUNT - 1);
    localparam logic [WORD_W-1:0]   ERASED_WORD = '1;
    localparam logic [QUAD_WORDS-1:0] FULL_MASK = '1;

    typedef logic [QUAD_WORDS-1:0][WORD_W-1:0] quad_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FINISH = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_WR_WAIT,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

>>> hdl/fqwc_ram.sv
`default_nettype none

module fqwc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 9216
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/flash_quad_write_combiner.sv
// flash quad write combiner: one item in, one result out. a write gathers a
// 32-bit word into a single pending four-word buffer, which is programmed into
// the quad store (a 9216 x 128 synchronous ram) when all four words are
// filled, when a write to another quad arrives, or on finish. the first write
// of a session erases the store by sweeping it with all ones, one quad per
// cycle, and that item then passes through the execute step a second time;
// after reset the same sweep runs once, with cmd_ready low. the block takes
// one item at a time: items that need no store read (rejects, buffer read
// hits, finish) get their result into the result register from the execute
// step; items that read the store issue the read in the execute step and
// take the word in a wait step, and a write that first flushes a different
// quad programs it in a first pass of the execute step. cmd_ready is
// high whenever the block is idle, even while the last result still waits in
// the result register; a result that finds that register still full is parked
// in a holding register, with cmd_ready low, until that register is taken.
// flash_fault only counts for an item that erases or programs; a fault latches
// session_error, which stays set (and blocks writes and finish) until reset.
`default_nettype none

module flash_quad_write_combiner
    import fqwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire logic [1:0]           command,
    input  wire logic [NUM_W-1:0]     word_number,
    input  wire logic [WORD_W-1:0]    write_data,
    input  wire logic                 flash_fault,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic                      ok,
    output logic      [WORD_W-1:0]    read_data,
    output logic                      session_error
);

    state_t state_reg, state_next;
    logic [QUAD_AW-1:0] clr_addr_reg, clr_addr_next;

    // session state
    logic started_reg, started_next;
    logic err_reg, err_next;
    logic pend_valid_reg, pend_valid_next;
    logic [QUAD_AW-1:0] pend_quad_reg, pend_quad_next;
    logic [QUAD_WORDS-1:0] mask_reg, mask_next;
    quad_t buf_reg, buf_next;

    // item being worked on
    logic [1:0] cmd_reg, cmd_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic fault_reg, fault_next;

    // held result when the result register is still full
    logic res_ok_reg, res_ok_next;
    logic [WORD_W-1:0] res_data_reg, res_data_next;
    logic res_err_reg, res_err_next;

    // result register
    logic rsp_valid_reg, rsp_valid_next;
    logic ok_reg, ok_next;
    logic [WORD_W-1:0] read_data_reg, read_data_next;
    logic sess_err_reg, sess_err_next;

    // store ram port
    logic mem_we, mem_re;
    logic [QUAD_AW-1:0] mem_waddr, mem_raddr;
    logic [QUAD_W-1:0] mem_wdata, mem_rdata;
    quad_t rd_quad;

    // item decode
    logic [QUAD_AW-1:0] quad_idx;
    logic [1:0] word_idx;
    logic in_range;
    logic [QUAD_WORDS-1:0] word_bit;

    // result of the current step
    logic done;
    logic res_ok;
    logic [WORD_W-1:0] res_data;

    // pending buffer as seen by a write to an erased quad
    logic [QUAD_WORDS-1:0] eff_mask, new_mask;
    quad_t eff_buf, new_buf;

    assign quad_idx = num_reg[QUAD_AW+1:2];
    assign word_idx = num_reg[1:0];
    assign in_range = ({1'b0, num_reg} < AREA_LIMIT);
    assign word_bit = QUAD_WORDS'(1) << word_idx;
    assign rd_quad  = mem_rdata;

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign ok            = ok_reg;
    assign read_data     = read_data_reg;
    assign session_error = sess_err_reg;

    fqwc_ram #(
        .WIDTH (QUAD_W),
        .DEPTH (QUAD_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        eff_mask = pend_valid_reg ? mask_reg : '0;
        eff_buf  = pend_valid_reg ? buf_reg : {QUAD_WORDS{ERASED_WORD}};
        new_mask = eff_mask | word_bit;
        new_buf  = eff_buf;
        new_buf[word_idx] = data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            started_reg    <= 1'b0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_quad_reg  <= '0;
            mask_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            started_reg    <= started_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            pend_quad_reg  <= pend_quad_next;
            mask_reg       <= mask_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        cmd_reg       <= cmd_next;
        num_reg       <= num_next;
        data_reg      <= data_next;
        fault_reg     <= fault_next;
        res_ok_reg    <= res_ok_next;
        res_data_reg  <= res_data_next;
        res_err_reg   <= res_err_next;
        ok_reg        <= ok_next;
        read_data_reg <= read_data_next;
        sess_err_reg  <= sess_err_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        started_next    = started_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_quad_next  = pend_quad_reg;
        mask_next       = mask_reg;
        buf_next        = buf_reg;
        cmd_next        = cmd_reg;
        num_next        = num_reg;
        data_next       = data_reg;
        fault_next      = fault_reg;
        res_ok_next     = res_ok_reg;
        res_data_next   = res_data_reg;
        res_err_next    = res_err_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ok_next         = ok_reg;
        read_data_next  = read_data_reg;
        sess_err_next   = sess_err_reg;

        mem_we    = 1'b0;
        mem_waddr = pend_quad_reg;
        mem_wdata = buf_reg;
        mem_re    = 1'b0;
        mem_raddr = quad_idx;

        done     = 1'b0;
        res_ok   = 1'b0;
        res_data = '0;

        unique case (state_reg)
            // erase sweep, after reset and at session start
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = {QUAD_WORDS{ERASED_WORD}};
                clr_addr_next = clr_addr_reg + QUAD_AW'(1);
                if (clr_addr_reg == LAST_QUAD)
                begin
                    clr_addr_next = '0;
                    state_next    = started_reg ? ST_EXEC : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = command;
                    num_next   = word_number;
                    data_next  = write_data;
                    fault_next = flash_fault;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_READ:
                    begin
                        if (!in_range)
                        begin
                            done = 1'b1;
                        end
                        else if (pend_valid_reg && pend_quad_reg == quad_idx
                                 && (mask_reg & word_bit) != '0)
                        begin
                            done     = 1'b1;
                            res_ok   = 1'b1;
                            res_data = buf_reg[word_idx];
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                    end

                    CMD_FINISH:
                    begin
                        if (err_reg)
                        begin
                            done = 1'b1;
                        end
                        else if (pend_valid_reg && fault_reg)
                        begin
                            err_next = 1'b1;
                            done     = 1'b1;
                        end
                        else
                        begin
                            // flush, then drop the session
                            mem_we          = pend_valid_reg;
                            started_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            pend_quad_next  = '0;
                            mask_next       = '0;
                            buf_next        = {QUAD_WORDS{ERASED_WORD}};
                            done            = 1'b1;
                            res_ok          = 1'b1;
                        end
                    end

                    CMD_WRITE:
                    begin
                        if (!in_range || err_reg)
                        begin
                            done = 1'b1;
                        end
                        else if (!started_reg)
                        begin
                            if (fault_reg)
                            begin
                                err_next = 1'b1;
                                done     = 1'b1;
                            end
                            else
                            begin
                                started_next  = 1'b1;
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end
                        end
                        else if (pend_valid_reg && pend_quad_reg != quad_idx)
                        begin
                            if (fault_reg)
                            begin
                                err_next = 1'b1;
                                done     = 1'b1;
                            end
                            else
                            begin
                                // flush the other quad, come back here
                                mem_we          = 1'b1;
                                pend_valid_next = 1'b0;
                                pend_quad_next  = '0;
                                mask_next       = '0;
                                buf_next        = {QUAD_WORDS{ERASED_WORD}};
                            end
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_WR_WAIT;
                        end
                    end

                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end

            ST_RD_WAIT:
            begin
                done     = 1'b1;
                res_ok   = 1'b1;
                res_data = rd_quad[word_idx];
            end

            ST_WR_WAIT:
            begin
                done = 1'b1;
                if (mem_rdata != {QUAD_WORDS{ERASED_WORD}})
                begin
                    // already programmed: compare only
                    res_ok = (rd_quad[word_idx] == data_reg);
                end
                else if ((eff_mask & word_bit) != '0)
                begin
                    res_ok = (eff_buf[word_idx] == data_reg);
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_quad_next  = quad_idx;
                    mask_next       = new_mask;
                    buf_next        = new_buf;
                    res_ok          = 1'b1;
                    if (new_mask == FULL_MASK)
                    begin
                        if (fault_reg)
                        begin
                            // buffer kept full, error latched
                            err_next = 1'b1;
                            res_ok   = 1'b0;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = quad_idx;
                            mem_wdata       = new_buf;
                            pend_valid_next = 1'b0;
                            pend_quad_next  = '0;
                            mask_next       = '0;
                            buf_next        = {QUAD_WORDS{ERASED_WORD}};
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    read_data_next = res_data_reg;
                    sess_err_next  = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result to the result register, or park it
        if (done)
        begin
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_valid_next = 1'b1;
                ok_next        = res_ok;
                read_data_next = res_data;
                sess_err_next  = err_next;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_ok_next   = res_ok;
                res_data_next = res_data;
                res_err_next  = err_next;
                state_next    = ST_RESP;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/fqwc_checker.sv
`default_nettype none

module fqwc_checker
    import fqwc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              ok,
    input wire logic [WORD_W-1:0] read_data,
    input wire logic              session_error
);

    // a waiting result holds still
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok)
            && $stable(read_data) && $stable(session_error))
        else $error("result changed while stalled");

    // only a successful read carries data
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_data != '0 |-> ok)
        else $error("nonzero read_data without ok");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item accepted while busy");

    // an accepted item, with no result showing, still shows none in the next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !rsp_valid |=> !rsp_valid)
        else $error("result appeared one cycle after accept");

endmodule

bind flash_quad_write_combiner fqwc_checker u_fqwc_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fqwc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int FAULT_ITEMS    = 60;     // last items, where flash faults may land
    localparam int CALM_FIRST     = 300;    // stretch of items with no random idling
    localparam int CALM_LAST      = 600;
    localparam int HOT_COUNT      = 6;
    localparam int WATCHDOG_LIMIT = 40000;  // covers the clear sweep and a full erase
    localparam int SETTLE_CYCLES  = 20;
    localparam int STEP_COUNT     = 25;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  ok;
        word_t read_data;
        logic  session_error;
    } reply_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [NUM_W-1:0] num;
        word_t            data;
        logic             fault;
        logic             typed;    // reply below is taken as is
        reply_t           reply;
    } step_t;

    localparam reply_t READ_ERASED = '{1'b1, ERASED_WORD, 1'b0};
    localparam reply_t REJECTED    = '{1'b0, 32'h0, 1'b0};
    localparam reply_t FROM_MODEL  = '{1'b0, 32'h0, 1'b0};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_ready;
    logic [1:0]       command = CMD_WRITE;
    logic [NUM_W-1:0] word_number = '0;
    word_t            write_data = '0;
    logic             flash_fault = 1'b0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    logic             ok;
    word_t            read_data;
    logic             session_error;

    flash_quad_write_combiner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .word_number   (word_number),
        .write_data    (write_data),
        .flash_fault   (flash_fault),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .ok            (ok),
        .read_data     (read_data),
        .session_error (session_error)
    );

    always #1 clk = ~clk;

    // predicted state of the combiner
    quad_t                 quad_mem [int];   // quads missing here read as erased
    logic                  sess_open;
    logic                  err_latched;
    logic                  buf_valid;
    int                    buf_quad;
    logic [QUAD_WORDS-1:0] buf_mask;
    quad_t                 buf_words;

    reply_t replies_due [$];
    int     failures = 0;
    int     stall_cycles = 0;
    logic   calm = 1'b0;
    int     hot_quads [HOT_COUNT];
    int     cur_hot = 0;

    function automatic quad_t quad_at(int q);
        quad_t erased;
        erased = '1;
        if (quad_mem.exists(q))
        begin
            return quad_mem[q];
        end
        return erased;
    endfunction

    function automatic void clear_buffer();
        buf_valid = 1'b0;
        buf_quad  = 0;
        buf_mask  = '0;
        buf_words = '1;
    endfunction

    // program the pending quad; a fault leaves the store and buffer alone
    function automatic logic program_buffer(logic fault);
        if (!buf_valid)
        begin
            return 1'b1;
        end
        if (fault)
        begin
            err_latched = 1'b1;
            return 1'b0;
        end
        quad_mem[buf_quad] = buf_words;
        clear_buffer();
        return 1'b1;
    endfunction

    // word as a read sees it: buffered data first, then the store
    function automatic word_t stored_word(int num);
        int    q;
        int    w;
        quad_t held;
        q = num / QUAD_WORDS;
        w = num % QUAD_WORDS;
        if (buf_valid && buf_quad == q && buf_mask[w])
        begin
            return buf_words[w];
        end
        held = quad_at(q);
        return held[w];
    endfunction

    function automatic logic write_word(int num, word_t data, logic fault);
        int    q;
        int    w;
        quad_t held;
        if (num >= AREA_WORDS || err_latched)
        begin
            return 1'b0;
        end
        // first write of a session erases the whole area
        if (!sess_open)
        begin
            if (fault)
            begin
                err_latched = 1'b1;
                return 1'b0;
            end
            quad_mem.delete();
            sess_open = 1'b1;
        end
        q = num / QUAD_WORDS;
        w = num % QUAD_WORDS;
        if (buf_valid && buf_quad != q)
        begin
            if (!program_buffer(fault))
            begin
                return 1'b0;
            end
        end
        // a programmed quad only compares
        held = quad_at(q);
        if (held != '1)
        begin
            return held[w] == data;
        end
        if (!buf_valid)
        begin
            clear_buffer();
            buf_valid = 1'b1;
            buf_quad  = q;
        end
        if (buf_mask[w])
        begin
            return buf_words[w] == data;
        end
        buf_words[w] = data;
        buf_mask[w]  = 1'b1;
        if (buf_mask == FULL_MASK)
        begin
            return program_buffer(fault);
        end
        return 1'b1;
    endfunction

    function automatic logic finish_session(logic fault);
        if (err_latched)
        begin
            return 1'b0;
        end
        if (!program_buffer(fault))
        begin
            return 1'b0;
        end
        sess_open   = 1'b0;
        err_latched = 1'b0;
        clear_buffer();
        return 1'b1;
    endfunction

    function automatic reply_t predict_reply(logic [1:0] cmd, int num, word_t data,
                                             logic fault);
        reply_t r;
        r = '0;
        case (cmd)
            CMD_WRITE:
            begin
                r.ok = write_word(num, data, fault);
            end
            CMD_READ:
            begin
                if (num < AREA_WORDS)
                begin
                    r.ok        = 1'b1;
                    r.read_data = stored_word(num);
                end
            end
            CMD_FINISH:
            begin
                r.ok = finish_session(fault);
            end
            default:
            begin
            end
        endcase
        r.session_error = err_latched;
        return r;
    endfunction

    // would this item erase or program in the current state
    function automatic logic touches_flash(logic [1:0] cmd, int num);
        int q;
        int w;
        q = num / QUAD_WORDS;
        w = num % QUAD_WORDS;
        if (err_latched)
        begin
            return 1'b0;
        end
        if (cmd == CMD_FINISH)
        begin
            return buf_valid;
        end
        if (cmd != CMD_WRITE || num >= AREA_WORDS)
        begin
            return 1'b0;
        end
        if (!sess_open || (buf_valid && buf_quad != q))
        begin
            return 1'b1;
        end
        return quad_at(q) == '1 && !buf_mask[w] &&
               (buf_mask | QUAD_WORDS'(1 << w)) == FULL_MASK;
    endfunction

    function automatic void pick_hot_quads();
        for (int i = 0; i < HOT_COUNT; i++)
        begin
            case ($urandom_range(9))
                0: hot_quads[i] = 0;
                1: hot_quads[i] = QUAD_COUNT - 1;
                default: hot_quads[i] = $urandom_range(QUAD_COUNT - 1);
            endcase
        end
        cur_hot = 0;
    endfunction

    function automatic void check_reply();
        reply_t want;
        if (replies_due.size() == 0)
        begin
            $error("reply arrived with no item outstanding");
            failures++;
            return;
        end
        want = replies_due.pop_front();
        if (ok !== want.ok)
        begin
            $error("ok: expected %0d, got %0d", want.ok, ok);
            failures++;
        end
        if (read_data !== want.read_data)
        begin
            $error("read_data: expected %08h, got %08h", want.read_data, read_data);
            failures++;
        end
        if (session_error !== want.session_error)
        begin
            $error("session_error: expected %0d, got %0d", want.session_error,
                   session_error);
            failures++;
        end
    endfunction

    // present one item, hold it until accepted, then predict its reply
    task automatic send_item(logic [1:0] cmd, logic [NUM_W-1:0] num, word_t data,
                             logic fault, logic typed, reply_t typed_reply);
        reply_t r;
        while (!calm && $urandom_range(99) < 15)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        command     <= cmd;
        word_number <= num;
        write_data  <= data;
        flash_fault <= fault;
        do
            @(posedge clk);
        while (!cmd_ready);
        r = predict_reply(cmd, num, data, fault);
        replies_due.push_back(typed ? typed_reply : r);
    endtask

    // hold the sender off until every reply is back
    task automatic drain_replies();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic random_item(logic live_faults);
        int         pick;
        int         num;
        word_t      data;
        logic [1:0] cmd;
        logic       fault;
        pick = $urandom_range(999);
        data = $urandom;
        num  = $urandom_range(AREA_WORDS - 1);
        cmd  = CMD_WRITE;
        if (pick < 15)
        begin
            // finish ends the session, next write erases again
            cmd = CMD_FINISH;
            num = $urandom_range(65535);
            if ($urandom_range(2) == 0)
            begin
                drain_replies();
            end
        end
        else if (pick < 45)
        begin
            cmd = CMD_UNUSED;
            num = $urandom_range(65535);
        end
        else if (pick < 125)
        begin
            // out of range numbers, the boundary itself now and then
            cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
            num = $urandom_range(7) == 0 ? AREA_WORDS : $urandom_range(65535, AREA_WORDS);
        end
        else if (pick < 400)
        begin
            cmd = CMD_READ;
            if ($urandom_range(4) != 0)
            begin
                num = hot_quads[$urandom_range(HOT_COUNT - 1)] * QUAD_WORDS +
                      $urandom_range(QUAD_WORDS - 1);
            end
        end
        else
        begin
            // mostly fills of one quad at a time, with random hops between quads
            if ($urandom_range(4) == 0)
            begin
                cur_hot = $urandom_range(HOT_COUNT - 1);
            end
            if ($urandom_range(9) != 0)
            begin
                num = hot_quads[cur_hot] * QUAD_WORDS + $urandom_range(QUAD_WORDS - 1);
            end
            case ($urandom_range(9))
                0, 1, 2: data = stored_word(num);
                3: data = ERASED_WORD;
                default: data = $urandom;
            endcase
        end
        if (live_faults)
        begin
            fault = $urandom_range(3) == 0;
        end
        else
        begin
            // faults only where the block must ignore them
            fault = touches_flash(cmd, num) ? 1'b0 : 1'($urandom_range(1));
        end
        send_item(cmd, num, data, fault, 1'b0, FROM_MODEL);
        if (cmd == CMD_FINISH)
        begin
            pick_hot_quads();
        end
    endtask

    // result side: random stalls, check every accepted reply
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            check_reply();
        end
        rsp_ready <= calm || $urandom_range(99) >= 15;
    end

    // cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        step_t steps [STEP_COUNT];
        step_t s;
        steps = '{
            // reads of an erased area, fault ignored on a read
            '{CMD_READ,   16'd0,     32'h0000_0000, 1'b1, 1'b1, READ_ERASED},
            '{CMD_READ,   16'd36863, 32'hFFFF_FFFF, 1'b0, 1'b1, READ_ERASED},
            // rejects: out of range and the unused command
            '{CMD_READ,   16'd36864, 32'h0000_0000, 1'b0, 1'b1, REJECTED},
            '{CMD_WRITE,  16'd65535, 32'h0000_0000, 1'b1, 1'b1, REJECTED},
            '{CMD_UNUSED, 16'd5,     32'h0000_0123, 1'b1, 1'b1, REJECTED},
            // session start erase, then buffering and compares in the buffer
            '{CMD_WRITE,  16'd0,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd1,     32'hFFFF_FFFF, 1'b1, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd1,     32'hFFFF_FFFF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd1,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_READ,   16'd0,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_READ,   16'd2,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            // full quad programs, then compares against the store
            '{CMD_WRITE,  16'd2,     32'hA5A5_A5A5, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd3,     32'h5A5A_5A5A, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd3,     32'h5A5A_5A5A, 1'b1, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd0,     32'h0000_0001, 1'b0, 1'b0, FROM_MODEL},
            // last quad, flushed by a write to another quad
            '{CMD_WRITE,  16'd36863, 32'hDEAD_BEEF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd4,     32'h1234_5678, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_READ,   16'd36863, 32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            // quad programmed as all ones counts as blank
            '{CMD_WRITE,  16'd8,     32'hFFFF_FFFF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd9,     32'hFFFF_FFFF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd10,    32'hFFFF_FFFF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd11,    32'hFFFF_FFFF, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_WRITE,  16'd8,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            // finish flushes, the store keeps its contents
            '{CMD_FINISH, 16'd0,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL},
            '{CMD_READ,   16'd8,     32'h0000_0000, 1'b0, 1'b0, FROM_MODEL}
        };
        quad_mem.delete();
        sess_open   = 1'b0;
        err_latched = 1'b0;
        clear_buffer();
        pick_hot_quads();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < STEP_COUNT; i++)
        begin
            s = steps[i];
            send_item(s.cmd, s.num, s.data, s.fault, s.typed, s.reply);
        end
        drain_replies();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = i >= CALM_FIRST && i < CALM_LAST;
            random_item(i >= RANDOM_ITEMS - FAULT_ITEMS);
        end
        calm = 1'b0;

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
